/* rtl/range_map_to_point_coords_macros.svh */
// Assertion macros shared by the checker of the range-to-point block.
`ifndef RANGE_MAP_TO_POINT_COORDS_MACROS_SVH
`define RANGE_MAP_TO_POINT_COORDS_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RMPC_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RMPC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/rmpc_pkg.sv */
// Shared types, constants and the arctangent table of the range-to-point block.
package rmpc_pkg;

    localparam int LAT_BITS      = 10;
    localparam int LON_BITS      = 10;
    localparam int CODE_BITS     = 16;
    localparam int SHIFT_BITS    = 4;
    localparam int STEP_BITS     = 20;
    localparam int COUNT_BITS    = 11;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;
    localparam int R_BITS        = 30;
    localparam int Q15_BITS      = 16;
    localparam int COORD_BITS    = 32;
    localparam int CORDIC_BITS   = 34;
    localparam int ANG_BITS      = 31;

    localparam int MAX_CORDIC    = 24;
    localparam int ANGLE_LATENCY = 9;
    localparam int CORDIC_TAIL   = 2;

    localparam logic [22:0]             TWO_PI_URAD  = 23'd6283185;
    localparam logic signed [33:0]      PI_Q30       = 34'sd3373259426;
    localparam logic signed [33:0]      HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [33:0]      TWO_PI_Q30   = 34'sd6746518852;
    localparam logic signed [33:0]      GAIN_Q30     = 34'sd652032874;
    localparam logic signed [31:0]      VOID_MARK_UM = 32'sd125000;
    localparam logic [CODE_BITS-1:0]    VOID_CODE    = 16'h8000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE,
        CFG_RADIUS_SHIFT,
        CFG_LAT_STEP,
        CFG_LON_STEP,
        CFG_LAT_COUNT,
        CFG_LON_COUNT,
        CFG_LAT_FIRST,
        CFG_LON_FIRST
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_CYL   = 2'd0,
        MODE_CART  = 2'd1,
        MODE_BILAT = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [Q15_BITS-1:0] sin_q15;
        logic signed [Q15_BITS-1:0] cos_q15;
    } trig_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_um;
        logic signed [COORD_BITS-1:0] y_um;
        logic signed [COORD_BITS-1:0] z_um;
        logic                         is_void;
        logic                         code_error;
    } point_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/range_map_to_point_coords.sv */
// Top level: range-scanner sample to point converter with config registers and output skid.
//
// Turns one range-scanner sample per clock, unless stalled, into an (x, y, z) point in um.
// A slave beat on s_axis carries latitude index, longitude index and the raw
// 16-bit radius code; the code is shifted left by radius_shift, the void code
// 0x8000 gives the 125000 um marker, and any other negative code is output as
// void with code_error set. In cylindrical mode the angle (lon - lon_first) *
// lon_step urad is reduced modulo 2*pi, folded and fed to a pipelined CORDIC;
// x = r*sin and z = -r*cos. Cartesian and bilateral modes give grid offsets with
// z = r (bilateral takes the latitude modulo half the latitude count through a
// ten-step pipelined remainder). The pipeline takes one beat every clock while
// the skid entry is free; it is built from the nine angle-reduction stages, one
// stage per CORDIC micro-rotation (at most 24), and the multiply and rounding
// stages. The whole pipe advances together; a two-entry output register and
// skid stage keep accepting input while a result waits on m_axis_tready, and
// s_axis_tready falls only once the skid entry is filled. Write the config port
// only while no beat is in flight.
module range_map_to_point_coords #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // sample in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // lat_index[9:0], lon_index[19:10], range_code[35:20]
    // point out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_um[31:0], y_um[63:32], z_um[95:64]
    output logic [1:0]  m_axis_tuser    // is_void[0], code_error[1]
);
    import rmpc_pkg::*;

    localparam int CORDIC_N   = (CORDIC_STAGES < MAX_CORDIC) ? CORDIC_STAGES : MAX_CORDIC;
    localparam int SIDE_DEPTH = ANGLE_LATENCY + CORDIC_N + CORDIC_TAIL;

    typedef struct packed {
        logic [LAT_BITS-1:0] lat;
        logic [LON_BITS-1:0] lon;
        logic [R_BITS-1:0]   r;
        logic                is_void;
        logic                code_error;
        logic [LAT_BITS-1:0] rem;
    } side_t;

    // ---------------- config registers ----------------
    logic [1:0]            mode_reg;
    logic [SHIFT_BITS-1:0] radius_shift_reg;
    logic [STEP_BITS-1:0]  lat_step_reg;
    logic [STEP_BITS-1:0]  lon_step_reg;
    logic [COUNT_BITS-1:0] lat_count_reg;
    logic [COUNT_BITS-1:0] lon_count_reg;
    logic [LAT_BITS-1:0]   lat_first_reg;
    logic [LON_BITS-1:0]   lon_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_CYL;
            radius_shift_reg <= '0;
            lat_step_reg     <= '0;
            lon_step_reg     <= '0;
            lat_count_reg    <= 11'd1024;
            lon_count_reg    <= 11'd1024;
            lat_first_reg    <= '0;
            lon_first_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:         mode_reg         <= cfg_data[1:0];
                CFG_RADIUS_SHIFT: radius_shift_reg <= cfg_data[SHIFT_BITS-1:0];
                CFG_LAT_STEP:     lat_step_reg     <= cfg_data[STEP_BITS-1:0];
                CFG_LON_STEP:     lon_step_reg     <= cfg_data[STEP_BITS-1:0];
                CFG_LAT_COUNT:    lat_count_reg    <= cfg_data[COUNT_BITS-1:0];
                CFG_LON_COUNT:    lon_count_reg    <= cfg_data[COUNT_BITS-1:0];
                CFG_LAT_FIRST:    lat_first_reg    <= cfg_data[LAT_BITS-1:0];
                CFG_LON_FIRST:    lon_first_reg    <= cfg_data[LON_BITS-1:0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    logic [LAT_BITS-1:0] half_lat;
    logic                is_cyl;
    logic                is_bilat;

    assign half_lat = lat_count_reg[COUNT_BITS-1:1];
    assign is_cyl   = (mode_reg == MODE_CYL);
    assign is_bilat = (mode_reg != MODE_CYL) && (mode_reg != MODE_CART);

    // ---------------- flow control ----------------
    // The pipe advances as a whole whenever the skid entry is free.
    logic en;
    logic skid_valid_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ---------------- input stage ----------------
    logic [LAT_BITS-1:0]          in_lat;
    logic [LON_BITS-1:0]          in_lon;
    logic [CODE_BITS-1:0]         in_code;
    logic                         in_void;
    logic signed [LON_BITS:0]     lon_diff;
    logic signed [31:0]           ang_full;
    side_t                        p0_next;

    always_comb
    begin
        in_lat   = s_axis_tdata[9:0];
        in_lon   = s_axis_tdata[19:10];
        in_code  = s_axis_tdata[35:20];
        in_void  = in_code[CODE_BITS-1];
        lon_diff = $signed({1'b0, in_lon}) - $signed({1'b0, lon_first_reg});
        ang_full = lon_diff * $signed({1'b0, lon_step_reg});
        p0_next.lat        = in_lat;
        p0_next.lon        = in_lon;
        p0_next.r          = in_void ? '0
                           : R_BITS'({15'd0, in_code[CODE_BITS-2:0]} << radius_shift_reg);
        p0_next.is_void    = in_void;
        p0_next.code_error = in_void && (in_code != VOID_CODE);
        p0_next.rem        = '0;
    end

    logic                        p0_vld_reg;
    side_t                       p0_reg;
    logic signed [ANG_BITS-1:0]  ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_vld_reg <= 1'b0;
        else if (en)
            p0_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            ang_reg <= ang_full[ANG_BITS-1:0];
        end
    end

    // ---------------- angle and CORDIC ----------------
    logic signed [CORDIC_BITS-1:0] z_q30;
    logic                          flip;
    trig_t                         trig;

    rmpc_angle u_angle (
        .clk      (clk),
        .en       (en),
        .ang_urad (ang_reg),
        .z_q30    (z_q30),
        .flip     (flip)
    );

    rmpc_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk   (clk),
        .en    (en),
        .z_q30 (z_q30),
        .flip  (flip),
        .trig  (trig)
    );

    // ---------------- side path ----------------
    // Carry the sample alongside the angle path; the first stages also work out
    // lat mod (lat_count/2) one quotient bit per stage.
    logic  side_vld_reg [SIDE_DEPTH];
    side_t side_reg     [SIDE_DEPTH];

    for (genvar k = 0; k < SIDE_DEPTH; k++)
    begin : g_side
        side_t prev;
        side_t nxt;
        logic  prev_vld;

        if (k == 0)
        begin : g_head
            assign prev     = p0_reg;
            assign prev_vld = p0_vld_reg;
        end
        else
        begin : g_tail
            assign prev     = side_reg[k-1];
            assign prev_vld = side_vld_reg[k-1];
        end

        if (k < LAT_BITS)
        begin : g_div
            logic [LAT_BITS:0] part;
            always_comb
            begin
                part = {prev.rem, prev.lat[LAT_BITS-1-k]};
                nxt  = prev;
                if (part >= {1'b0, half_lat})
                    nxt.rem = LAT_BITS'(part - {1'b0, half_lat});
                else
                    nxt.rem = part[LAT_BITS-1:0];
            end
        end
        else
        begin : g_pass
            assign nxt = prev;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_vld_reg[k] <= 1'b0;
            else if (en)
                side_vld_reg[k] <= prev_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[k] <= nxt;
        end
    end

    // ---------------- products and rounding ----------------
    side_t                   sd;
    logic [LAT_BITS-1:0]     lat_sel;
    logic signed [46:0]      px;
    logic signed [46:0]      pz;
    logic signed [12:0]      ydiff;
    logic signed [11:0]      xdiff;

    assign sd = side_reg[SIDE_DEPTH-1];

    always_comb
    begin
        lat_sel = (is_bilat && half_lat != '0) ? sd.rem : sd.lat;
        px      = $signed({1'b0, sd.r}) * trig.sin_q15;
        pz      = $signed({1'b0, sd.r}) * trig.cos_q15;
        if (is_cyl)
            ydiff = $signed({3'b0, sd.lat}) - $signed({3'b0, lat_first_reg})
                  - $signed({3'b0, half_lat});
        else
            ydiff = $signed({3'b0, lat_sel}) - $signed({2'b0, lat_count_reg});
        xdiff   = $signed({2'b0, sd.lon}) - $signed({2'b0, lon_count_reg[COUNT_BITS-1:1]});
    end

    logic               m1_vld_reg;
    side_t              m1_side_reg;
    logic signed [46:0] px_reg;
    logic signed [46:0] pz_reg;
    logic signed [12:0] ydiff_reg;
    logic signed [11:0] xdiff_reg;

    logic               m2_vld_reg;
    side_t              m2_side_reg;
    logic [46:0]        mx_reg;
    logic [46:0]        mz_reg;
    logic               sx_reg;
    logic               sz_reg;
    logic signed [31:0] yprod_reg;
    logic signed [31:0] xprod_reg;

    logic               m3_vld_reg;
    point_t             m3_reg;

    logic signed [33:0] yprod;
    logic signed [33:0] xprod;
    logic [31:0]        qx;
    logic [31:0]        qz;
    logic [31:0]        xr;
    logic [31:0]        zr;
    point_t             pt_next;

    always_comb
    begin
        yprod = ydiff_reg * $signed({1'b0, lat_step_reg});
        xprod = xdiff_reg * $signed({1'b0, lon_step_reg});
        qx    = 32'(({1'b0, mx_reg} + 48'd16384) >> 15);
        qz    = 32'(({1'b0, mz_reg} + 48'd16384) >> 15);
        xr    = sx_reg ? 32'(-qx) : qx;
        zr    = sz_reg ? qz : 32'(-qz);   // z is the negated rounded product
        pt_next.is_void    = m2_side_reg.is_void;
        pt_next.code_error = m2_side_reg.code_error;
        if (is_cyl)
        begin
            pt_next.x_um = m2_side_reg.is_void ? '0 : $signed(xr);
            pt_next.y_um = m2_side_reg.is_void ? VOID_MARK_UM : yprod_reg;
            pt_next.z_um = m2_side_reg.is_void ? '0 : $signed(zr);
        end
        else
        begin
            pt_next.x_um = xprod_reg;
            pt_next.y_um = yprod_reg;
            pt_next.z_um = m2_side_reg.is_void ? VOID_MARK_UM
                         : $signed({2'b0, m2_side_reg.r});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= side_vld_reg[SIDE_DEPTH-1];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg <= sd;
            px_reg      <= px;
            pz_reg      <= pz;
            ydiff_reg   <= ydiff;
            xdiff_reg   <= xdiff;

            m2_side_reg <= m1_side_reg;
            mx_reg      <= px_reg[46] ? 47'(-px_reg) : px_reg;
            mz_reg      <= pz_reg[46] ? 47'(-pz_reg) : pz_reg;
            sx_reg      <= px_reg[46];
            sz_reg      <= pz_reg[46];
            yprod_reg   <= yprod[31:0];
            xprod_reg   <= xprod[31:0];

            m3_reg      <= pt_next;
        end
    end

    // ---------------- output register and skid ----------------
    logic   out_valid_reg;
    point_t out_data_reg;
    point_t skid_data_reg;
    logic   push;

    assign push = en && m3_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the skid entry first
            if (m_axis_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_data_reg <= m3_reg;
            else
                out_data_reg <= m3_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.z_um, out_data_reg.y_um, out_data_reg.x_um};
    assign m_axis_tuser  = {out_data_reg.code_error, out_data_reg.is_void};

endmodule

/* rtl/rmpc_angle.sv */
// Angle reduction: microradians modulo 2*pi, scale to Q.30 radians, fold to +-pi/2.
module rmpc_angle (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [rmpc_pkg::ANG_BITS-1:0] ang_urad,
    output logic signed [rmpc_pkg::CORDIC_BITS-1:0] z_q30,
    output logic                                 flip
);
    import rmpc_pkg::*;

    // reciprocals for the two constant divisions; each estimate is low by at most one
    localparam logic [17:0] MOD_MUL   = 18'((64'd1 << 40) / 64'd6283185);
    localparam logic [23:0] DIV_MUL   = 24'((64'd1 << 37) / 64'd15625);
    localparam logic [13:0] DIV_CONST = 14'd15625;
    localparam logic [13:0] FRAC_MUL  = 14'd11591;
    localparam logic [36:0] FRAC_BIAS = 37'd7812;
    localparam logic [10:0] INT_MUL   = 11'd1073;

    logic [29:0] mag1_reg;
    logic        neg1_reg;
    logic [7:0]  q1_reg;
    logic [23:0] rem2_reg;
    logic        neg2_reg;
    logic [22:0] a3_reg;
    logic [36:0] n2_4_reg;
    logic [22:0] a4_reg;
    logic [36:0] n2_5_reg;
    logic [22:0] q2_5_reg;
    logic [22:0] a5_reg;
    logic [14:0] r2_6_reg;
    logic [22:0] q2_6_reg;
    logic [22:0] a6_reg;
    logic [32:0] zq_reg;
    logic signed [33:0] zw_reg;
    logic signed [33:0] z_reg;
    logic        flip_reg;

    logic [29:0] mag;
    logic [47:0] prod1;
    logic [29:0] qd1;
    logic [29:0] rem_full;
    logic [23:0] r_c;
    logic [23:0] a_c;
    logic [36:0] n2;
    logic [60:0] prod5;
    logic [36:0] qd2;
    logic [36:0] r2_full;
    logic [32:0] zq;
    logic signed [33:0] zs;

    always_comb
    begin
        mag      = ang_urad[ANG_BITS-1] ? 30'(-ang_urad) : ang_urad[29:0];
        prod1    = 48'(mag) * 48'(MOD_MUL);
        qd1      = 30'(q1_reg) * 30'(TWO_PI_URAD);
        rem_full = mag1_reg - qd1;
        r_c      = (rem2_reg >= 24'(TWO_PI_URAD)) ? rem2_reg - 24'(TWO_PI_URAD) : rem2_reg;
        a_c      = (neg2_reg && r_c != 24'd0) ? 24'(TWO_PI_URAD) - r_c : r_c;
        n2       = 37'(a3_reg) * 37'(FRAC_MUL) + FRAC_BIAS;
        prod5    = 61'(n2_4_reg) * 61'(DIV_MUL);
        qd2      = 37'(q2_5_reg) * 37'(DIV_CONST);
        r2_full  = n2_5_reg - qd2;
        zq       = 33'(a6_reg) * 33'(INT_MUL) + 33'(q2_6_reg)
                 + 33'(r2_6_reg >= 15'(DIV_CONST));
        zs       = $signed({1'b0, zq_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient estimate and magnitude
            mag1_reg <= mag;
            neg1_reg <= ang_urad[ANG_BITS-1];
            q1_reg   <= prod1[47:40];
            // remainder, below twice the modulus
            rem2_reg <= rem_full[23:0];
            neg2_reg <= neg1_reg;
            // correct once and wrap negatives into [0, 2*pi)
            a3_reg   <= a_c[22:0];
            // fractional part of a * 2^24 / 15625 with rounding bias
            n2_4_reg <= n2;
            a4_reg   <= a3_reg;
            n2_5_reg <= n2_4_reg;
            q2_5_reg <= prod5[59:37];
            a5_reg   <= a4_reg;
            r2_6_reg <= r2_full[14:0];
            q2_6_reg <= q2_5_reg;
            a6_reg   <= a5_reg;
            zq_reg   <= zq;
            // move into (-pi, pi]
            zw_reg   <= (zs > PI_Q30) ? zs - TWO_PI_Q30 : zs;
            // fold into [-pi/2, pi/2]; folding by pi negates sin and cos
            if (zw_reg > HALF_PI_Q30)
            begin
                z_reg    <= zw_reg - PI_Q30;
                flip_reg <= 1'b1;
            end
            else if (zw_reg < -HALF_PI_Q30)
            begin
                z_reg    <= zw_reg + PI_Q30;
                flip_reg <= 1'b1;
            end
            else
            begin
                z_reg    <= zw_reg;
                flip_reg <= 1'b0;
            end
        end
    end

    assign z_q30 = z_reg;
    assign flip  = flip_reg;

endmodule

/* rtl/rmpc_cordic.sv */
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, Q1.15 sin and cos out.
module rmpc_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [rmpc_pkg::CORDIC_BITS-1:0] z_q30,
    input  logic                                    flip,
    output rmpc_pkg::trig_t                         trig
);
    import rmpc_pkg::*;

    localparam int N = (STAGES < MAX_CORDIC) ? STAGES : MAX_CORDIC;

    logic signed [CORDIC_BITS-1:0] x_reg [N];
    logic signed [CORDIC_BITS-1:0] y_reg [N];
    logic signed [CORDIC_BITS-1:0] z_reg [N];
    logic                          flip_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [CORDIC_BITS-1:0] xp;
        logic signed [CORDIC_BITS-1:0] yp;
        logic signed [CORDIC_BITS-1:0] zp;
        logic                          fp;
        logic signed [CORDIC_BITS-1:0] ang;

        if (i == 0)
        begin : g_first
            assign xp = GAIN_Q30;
            assign yp = '0;
            assign zp = z_q30;
            assign fp = flip;
        end
        else
        begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign fp = flip_reg[i-1];
        end

        assign ang = $signed(CORDIC_BITS'(atan_q30(5'(i))));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zp >= 0)
                begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    z_reg[i] <= zp - ang;
                end
                else
                begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    z_reg[i] <= zp + ang;
                end
                flip_reg[i] <= fp;
            end
        end
    end

    // round Q.30 to Q1.15 half away from zero, apply the fold sign, saturate
    logic [CORDIC_BITS-1:0] mc_reg;
    logic [CORDIC_BITS-1:0] ms_reg;
    logic                   nc_reg;
    logic                   ns_reg;
    trig_t                  trig_reg;

    logic [CORDIC_BITS-1:0] mc;
    logic [CORDIC_BITS-1:0] ms;
    logic [19:0]            qc;
    logic [19:0]            qs;
    logic signed [20:0]     vc;
    logic signed [20:0]     vs;
    trig_t                  trig_next;

    always_comb
    begin
        mc = x_reg[N-1][CORDIC_BITS-1] ? CORDIC_BITS'(-x_reg[N-1]) : x_reg[N-1];
        ms = y_reg[N-1][CORDIC_BITS-1] ? CORDIC_BITS'(-y_reg[N-1]) : y_reg[N-1];
        qc = 20'((mc_reg + CORDIC_BITS'(16384)) >> 15);
        qs = 20'((ms_reg + CORDIC_BITS'(16384)) >> 15);
        vc = nc_reg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        vs = ns_reg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        if (vc > 21'sd32767)
            trig_next.cos_q15 = 16'sh7fff;
        else if (vc < -21'sd32768)
            trig_next.cos_q15 = 16'sh8000;
        else
            trig_next.cos_q15 = vc[15:0];
        if (vs > 21'sd32767)
            trig_next.sin_q15 = 16'sh7fff;
        else if (vs < -21'sd32768)
            trig_next.sin_q15 = 16'sh8000;
        else
            trig_next.sin_q15 = vs[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mc_reg   <= mc;
            ms_reg   <= ms;
            nc_reg   <= x_reg[N-1][CORDIC_BITS-1] ^ flip_reg[N-1];
            ns_reg   <= y_reg[N-1][CORDIC_BITS-1] ^ flip_reg[N-1];
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

/* rtl/rmpc_checker.sv */
// Port-level checker for the range-to-point block and its bind.
`include "range_map_to_point_coords_macros.svh"

module rmpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import rmpc_pkg::*;

    // a stalled output beat holds
    `RMPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

    // a bad code is always reported as void too
    `RMPC_ASSERT_NOW(a_err_void, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "code_error without is_void")

    // a void point carries the marker in y (cylindrical) or z (grid modes)
    `RMPC_ASSERT_NOW(a_void_mark, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[63:32] == VOID_MARK_UM || m_axis_tdata[95:64] == VOID_MARK_UM, "void point without marker")

    // input backpressure only ever comes from a full output side
    `RMPC_ASSERT_NOW(a_skid_full, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

endmodule

bind range_map_to_point_coords rmpc_checker u_rmpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
